/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Request operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // One stored entry
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } entry_t;

  // Result of one request, handed from the sequencer to the output register
  typedef struct packed {
    logic signed [31:0] head_value;
    logic signed [15:0] head_prio;
    logic               underflow;
    logic               overflow;
  } res_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_CMP,
    ST_POP_RD,
    ST_POP_WR,
    ST_HEAD_RD,
    ST_HEAD_WAIT,
    ST_DONE
  } state_t;

endpackage

/* rtl/spq_entry_ram.sv */
// ----------------------------------------------------------------------------
// spq_entry_ram
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_entry_ram #(
  parameter  int DEPTH = 16,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  spq_pkg::entry_t     wdata,
  input  logic [IDX_W-1:0]    raddr,
  output spq_pkg::entry_t     rd_data
);
  import spq_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: walks the entry memory one entry at a time, shifting
// entries to make room on push or to close the gap on pop, using one
// signed priority comparator to find the insertion point.
// ----------------------------------------------------------------------------
module spq_ctrl #(
  parameter  int CAPACITY = 16,
  localparam int IDX_W    = $clog2(CAPACITY),
  localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  // request side
  input  logic                start,
  input  logic                start_op,
  input  logic signed [31:0]  start_value,
  input  logic signed [15:0]  start_prio,
  output logic                idle,
  // result side
  input  logic                out_free,
  output logic                done,
  output spq_pkg::res_t       res,
  output logic [CNT_W-1:0]    count,
  // entry memory
  output logic                mem_we,
  output logic [IDX_W-1:0]    mem_waddr,
  output spq_pkg::entry_t     mem_wdata,
  output logic [IDX_W-1:0]    mem_raddr,
  input  spq_pkg::entry_t     mem_rdata
);
  import spq_pkg::*;

  localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ZERO_C = '0;
  localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  entry_t             item_r, item_nxt;
  res_t               res_r, res_nxt;

  logic [CNT_W-1:0]   pos_dec;
  logic [CNT_W-1:0]   pos_inc;
  logic               prio_le;

  // Shared compare unit and cursor arithmetic
  assign prio_le = (mem_rdata.prio <= item_r.prio);
  assign pos_dec = pos_r - ONE_C;
  assign pos_inc = pos_r + ONE_C;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (start_op == OP_PUSH) begin
            state_nxt = (cnt_r == CAP_C) ? ST_HEAD_RD : ST_PUSH_RD;
          end else begin
            state_nxt = (cnt_r == ZERO_C) ? ST_HEAD_RD : ST_POP_RD;
          end
        end
      end
      ST_PUSH_RD: begin
        state_nxt = (pos_r == ZERO_C) ? ST_HEAD_RD : ST_PUSH_CMP;
      end
      ST_PUSH_CMP: begin
        state_nxt = prio_le ? ST_HEAD_RD : ST_PUSH_RD;
      end
      ST_POP_RD: begin
        state_nxt = (pos_r == cnt_r) ? ST_HEAD_RD : ST_POP_WR;
      end
      ST_POP_WR: begin
        state_nxt = ST_POP_RD;
      end
      ST_HEAD_RD: begin
        state_nxt = (cnt_r == ZERO_C) ? ST_DONE : ST_HEAD_WAIT;
      end
      ST_HEAD_WAIT: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    item_nxt  = item_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = pos_r[IDX_W-1:0];
    mem_wdata = item_r;
    mem_raddr = pos_dec[IDX_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt.value = start_value;
          item_nxt.prio  = start_prio;
          res_nxt.underflow = (start_op == OP_POP) && (cnt_r == ZERO_C);
          res_nxt.overflow  = (start_op == OP_PUSH) && (cnt_r == CAP_C);
          pos_nxt = (start_op == OP_PUSH) ? cnt_r : ONE_C;
        end
      end
      ST_PUSH_RD: begin
        // reached the head: new entry goes to slot 0
        if (pos_r == ZERO_C) begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + ONE_C;
        end
      end
      ST_PUSH_CMP: begin
        mem_we = 1'b1;
        if (prio_le) begin
          cnt_nxt = cnt_r + ONE_C;
        end else begin
          // move the lower-ranked entry one slot back
          mem_wdata = mem_rdata;
          pos_nxt   = pos_dec;
        end
      end
      ST_POP_RD: begin
        mem_raddr = pos_r[IDX_W-1:0];
        if (pos_r == cnt_r) begin
          cnt_nxt = cnt_r - ONE_C;
        end
      end
      ST_POP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_dec[IDX_W-1:0];
        mem_wdata = mem_rdata;
        pos_nxt   = pos_inc;
      end
      ST_HEAD_RD: begin
        mem_raddr = '0;
        if (cnt_r == ZERO_C) begin
          res_nxt.head_value = '0;
          res_nxt.head_prio  = '0;
        end
      end
      ST_HEAD_WAIT: begin
        res_nxt.head_value = mem_rdata.value;
        res_nxt.head_prio  = mem_rdata.prio;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign idle  = (state_r == ST_IDLE);
  assign done  = (state_r == ST_DONE);
  assign res   = res_r;
  assign count = cnt_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C)
    else $error("held count exceeds capacity");

  a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PUSH_CMP |-> $past(state_r) == ST_PUSH_RD)
    else $error("compare step without a preceding read");

  a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_r.overflow) |-> cnt_r == CAP_C)
    else $error("overflow reported on a queue that is not full");

  a_under_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_r.underflow) |->
      (cnt_r == ZERO_C && res_r.head_value == '0 && res_r.head_prio == '0))
    else $error("underflow reported on a queue that is not empty");

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_PUSH_RD || state_r == ST_PUSH_CMP ||
                state_r == ST_POP_WR))
    else $error("memory written outside a shift step");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_free) |=> state_r == ST_DONE)
    else $error("result left before the output register was free");
`endif

endmodule

/* rtl/sorted_priority_queue_unit.sv */
// Flow: one request at a time; in_ready rises with out_valid once the
//   read/compare/write walk of the entry memory ends; a held result stalls.
// Reset: synchronous active-low rst_n empties the queue and clears out_valid;
//   entry memory contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue kept sorted in a memory, lowest priority number first.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic signed [31:0]  in_item_value,
  input  logic signed [15:0]  in_item_priority,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_head_value,
  output logic signed [15:0]  out_head_priority,
  output logic [4:0]          out_entry_count,
  output logic                out_is_empty,
  output logic                out_underflow,
  output logic                out_overflow
);
  import spq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic               start;
  logic               idle;
  logic               done;
  logic               out_free;
  res_t               res;
  logic [CNT_W-1:0]   count;
  logic [CNT_W+4:0]   count_ext;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  entry_t             mem_rdata;

  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r;
  logic [4:0]         out_cnt_r;
  logic               out_empty_r;

  assign in_ready = idle;
  assign start    = in_valid && idle;
  assign out_free = !out_valid_r || out_ready;

  spq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .start_op    (in_op),
    .start_value (in_item_value),
    .start_prio  (in_item_priority),
    .idle        (idle),
    .out_free    (out_free),
    .done        (done),
    .res         (res),
    .count       (count),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  spq_entry_ram #(.DEPTH(CAPACITY)) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rd_data (mem_rdata)
  );

  // entry count field wraps to five bits
  assign count_ext = {5'b0, count};

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (done && out_free) begin
      out_res_r   <= res;
      out_cnt_r   <= count_ext[4:0];
      out_empty_r <= (count == '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_head_value    = out_res_r.head_value;
  assign out_head_priority = out_res_r.head_prio;
  assign out_entry_count   = out_cnt_r;
  assign out_is_empty      = out_empty_r;
  assign out_underflow     = out_res_r.underflow;
  assign out_overflow      = out_res_r.overflow;

endmodule

/* tb/sv/sorted_priority_queue_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_test
// Self-checking bench for the sorted priority queue. Push and pop requests go
// in over the request channel. A shadow copy of the queue predicts the result
// of each accepted request, and each returned result is checked field by field.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_test;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 48;
  localparam int PRINT_LIMIT  = 40;

  // Expected status after one request
  typedef struct packed {
    logic signed [31:0] head_value;
    logic signed [15:0] head_priority;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic               underflow;
    logic               overflow;
  } queue_status_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_op = OP_PUSH;
  logic signed [31:0] in_item_value = '0;
  logic signed [15:0] in_item_priority = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_head_value;
  logic signed [15:0] out_head_priority;
  logic [4:0]         out_entry_count;
  logic               out_is_empty;
  logic               out_underflow;
  logic               out_overflow;

  // Shadow queue, sorted, head at index 0
  entry_t        shadow_entries [QUEUE_DEPTH];
  int            shadow_count = 0;
  queue_status_t pending_results [$];
  queue_status_t oldest_expected;

  int error_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  sorted_priority_queue_unit #(
    .CAPACITY(QUEUE_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_head_value   (out_head_value),
    .out_head_priority(out_head_priority),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_underflow    (out_underflow),
    .out_overflow     (out_overflow)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    if (error_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Apply one request to the shadow queue and return the status it leaves
  function automatic queue_status_t apply_request(input logic op,
                                                  input logic signed [31:0] val,
                                                  input logic signed [15:0] pri);
    queue_status_t st;
    int slot;
    st = '0;
    if (op == OP_PUSH) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        st.overflow = 1'b1;
      end else begin
        // behind every held entry of equal or lower priority number
        slot = 0;
        while (slot < shadow_count && shadow_entries[slot].prio <= pri) slot++;
        for (int i = shadow_count; i > slot; i--) shadow_entries[i] = shadow_entries[i - 1];
        shadow_entries[slot].value = val;
        shadow_entries[slot].prio  = pri;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        st.underflow = 1'b1;
      end else begin
        for (int i = 1; i < shadow_count; i++) shadow_entries[i - 1] = shadow_entries[i];
        shadow_count--;
      end
    end
    if (shadow_count > 0) begin
      st.head_value    = shadow_entries[0].value;
      st.head_priority = shadow_entries[0].prio;
    end
    st.entry_count = 5'(shadow_count);
    st.is_empty    = (shadow_count == 0);
    return st;
  endfunction

  // Send one request; record its expected status once accepted
  task automatic send_request(input logic op, input logic signed [31:0] val,
                              input logic signed [15:0] pri);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_item_value    <= val;
    in_item_priority <= pri;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_request(op, val, pri));
  endtask

  // Result check and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        oldest_expected = pending_results.pop_front();
        if (out_head_value !== oldest_expected.head_value)
          report_error($sformatf("head_value got %0d expected %0d",
                                 out_head_value, oldest_expected.head_value));
        if (out_head_priority !== oldest_expected.head_priority)
          report_error($sformatf("head_priority got %0d expected %0d",
                                 out_head_priority, oldest_expected.head_priority));
        if (out_entry_count !== oldest_expected.entry_count)
          report_error($sformatf("entry_count got %0d expected %0d",
                                 out_entry_count, oldest_expected.entry_count));
        if (out_is_empty !== oldest_expected.is_empty)
          report_error($sformatf("is_empty got %b expected %b",
                                 out_is_empty, oldest_expected.is_empty));
        if (out_underflow !== oldest_expected.underflow)
          report_error($sformatf("underflow got %b expected %b",
                                 out_underflow, oldest_expected.underflow));
        if (out_overflow !== oldest_expected.overflow)
          report_error($sformatf("overflow got %b expected %b",
                                 out_overflow, oldest_expected.overflow));
      end
    end
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Pop with nothing held
  task automatic test_pop_on_empty();
    send_request(OP_POP, 32'h5A5A_A5A5, 16'h1234);
  endtask

  // Extreme values and priorities, then drain past empty
  task automatic test_extreme_fields();
    send_request(OP_PUSH, 32'h7FFF_FFFF, 16'h7FFF);
    send_request(OP_PUSH, 32'h8000_0000, 16'h8000);
    send_request(OP_POP, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(OP_POP, 32'h0, 16'h0);
    send_request(OP_POP, 32'h0, 16'h0);
  endtask

  // Fill with many ties, then one push too many (ties the head priority)
  task automatic test_fill_to_overflow();
    logic signed [15:0] pri;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      case (k)
        0:       pri = 16'h7FFF;
        1:       pri = 16'h8000;
        default: pri = 16'(k % 3) - 16'sd1;
      endcase
      send_request(OP_PUSH, (k == 2) ? 32'hFFFF_FFFF : 32'(k * 3 + 1), pri);
    end
    send_request(OP_PUSH, 32'hDEAD_BEEF, 16'h8000);
  endtask

  // Bursts biased toward filling, draining or churning the queue
  task automatic test_random_traffic(input int n_requests, input int idle_pct,
                                     input int stall_pct);
    int burst_left;
    int push_bias;
    logic op;
    logic signed [31:0] val;
    logic signed [15:0] pri;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    burst_left = 0;
    push_bias  = 50;
    for (int n = 0; n < n_requests; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 8);
        case ($urandom_range(3))
          0:       push_bias = 85;
          1:       push_bias = 15;
          default: push_bias = 55;
        endcase
      end
      burst_left--;
      op = ($urandom_range(99) < push_bias) ? OP_PUSH : OP_POP;
      case ($urandom_range(3))
        0:       pri = 16'($urandom);
        1:       pri = 16'($urandom_range(3));
        2:       pri = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        default: pri = 16'($urandom_range(20)) - 16'sd10;
      endcase
      case ($urandom_range(7))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        default: val = $urandom;
      endcase
      send_request(op, val, pri);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pop_on_empty();
    test_extreme_fields();
    test_fill_to_overflow();
    test_random_traffic(282, 0, 0);
    test_random_traffic(282, 81, 0);
    test_random_traffic(282, 0, 81);
    test_random_traffic(282, 34, 34);
    in_valid <= 1'b0;

    // Let every result come back, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
